// ===== rtl/rmst_pkg.sv =====
`default_nettype none
package rmst_pkg;

	localparam int LEAF_BITS = 10;
	localparam int NODE_BITS = LEAF_BITS + 1;
	localparam int LEAVES = 1 << LEAF_BITS;
	localparam int NODE_COUNT = 2 * LEAVES;
	localparam int DATA_BITS = 32;
	localparam int MAX_BITS = DATA_BITS - 1;

	localparam logic [LEAF_BITS-1:0] POS_MIN = LEAF_BITS'(1);
	localparam logic [LEAF_BITS-1:0] POS_MAX = LEAF_BITS'(LEAVES - 2);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_READ,
		ST_WR_UPD,
		ST_Q_READ,
		ST_Q_PAIR,
		ST_Q_FIN
	} rmst_state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic wr_read;
		logic wr_upd;
		logic q_read;
		logic q_pair;
		logic emit;
		logic emit_query;
		logic emit_bad;
	} rmst_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic req_ok;
		logic req_query;
		logic wr_last;
		logic q_more;
	} rmst_sts_t;

endpackage
`default_nettype wire

// ===== rtl/range_max_segment_tree_unit.sv =====
// range max segment tree: a write stores the leaf, then per level reads the sibling
// and updates the parent up to the root; a query reads and pairs the boundary
// siblings per level, then finishes; a rejected request raises done with bad_request.
// node memory: one write port, two registered read ports; done pulses for one cycle.
// after reset all 2048 nodes of the node memory are cleared with busy high.
// the result goes out unconditionally: the receiver cannot stall.
`default_nettype none
module range_max_segment_tree_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   req_type,
	input  wire logic [rmst_pkg::LEAF_BITS-1:0]         left_pos,
	input  wire logic [rmst_pkg::LEAF_BITS-1:0]         right_pos,
	input  wire logic signed [rmst_pkg::DATA_BITS-1:0]  new_value,
	output logic                                        done,
	output logic [rmst_pkg::MAX_BITS-1:0]               max_value,
	output logic                                        bad_request
);
	import rmst_pkg::*;

	rmst_cmd_t cmd;
	rmst_sts_t sts;

	rmst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rmst_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.left_pos    (left_pos),
		.right_pos   (right_pos),
		.new_value   (new_value),
		.done        (done),
		.max_value   (max_value),
		.bad_request (bad_request)
	);

endmodule
`default_nettype wire

// ===== rtl/rmst_ctrl.sv =====
`default_nettype none
module rmst_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire rmst_pkg::rmst_sts_t sts,
	output rmst_pkg::rmst_cmd_t     cmd,
	output logic                    busy
);
	import rmst_pkg::*;

	rmst_state_t state_q;
	rmst_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && sts.req_ok) begin
					state_nxt = sts.req_query ? ST_Q_READ : ST_WR_READ;
				end
			end
			ST_WR_READ: state_nxt = ST_WR_UPD;
			ST_WR_UPD: begin
				state_nxt = sts.wr_last ? ST_IDLE : ST_WR_READ;
			end
			ST_Q_READ: state_nxt = ST_Q_PAIR;
			ST_Q_PAIR: begin
				state_nxt = sts.q_more ? ST_Q_READ : ST_Q_FIN;
			end
			ST_Q_FIN: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!sts.req_ok) begin
						cmd.emit = 1'b1;
						cmd.emit_bad = 1'b1;
					end
				end
			end
			ST_WR_READ: cmd.wr_read = 1'b1;
			ST_WR_UPD: begin
				cmd.wr_upd = 1'b1;
				cmd.emit = sts.wr_last;
			end
			ST_Q_READ: cmd.q_read = 1'b1;
			ST_Q_PAIR: cmd.q_pair = 1'b1;
			ST_Q_FIN: begin
				cmd.emit = 1'b1;
				cmd.emit_query = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/rmst_datapath.sv =====
`default_nettype none
module rmst_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rmst_pkg::rmst_cmd_t           cmd,
	output rmst_pkg::rmst_sts_t                sts,
	input  wire logic                          req_type,
	input  wire logic [rmst_pkg::LEAF_BITS-1:0] left_pos,
	input  wire logic [rmst_pkg::LEAF_BITS-1:0] right_pos,
	input  wire logic signed [rmst_pkg::DATA_BITS-1:0] new_value,
	output logic                               done,
	output logic [rmst_pkg::MAX_BITS-1:0]      max_value,
	output logic                               bad_request
);
	import rmst_pkg::*;

	logic signed [DATA_BITS-1:0] mem [NODE_COUNT];

	logic [NODE_BITS-1:0]        clr_q;
	logic [NODE_BITS-1:0]        idx_q;
	logic [NODE_BITS-1:0]        a_q;
	logic [NODE_BITS-1:0]        b_q;
	logic signed [DATA_BITS-1:0] cur_q;
	logic signed [DATA_BITS-1:0] best_q;
	logic signed [DATA_BITS-1:0] pair_q;
	logic signed [DATA_BITS-1:0] rd_a_q;
	logic signed [DATA_BITS-1:0] rd_b_q;
	logic                        fa_q;
	logic                        fb_q;
	logic                        done_q;
	logic [MAX_BITS-1:0]         max_q;
	logic                        bad_q;

	logic                        left_ok;
	logic                        right_ok;
	logic                        req_ok;
	logic                        leaf_wr;
	logic [NODE_BITS-1:0]        parent;
	logic signed [DATA_BITS-1:0] wmax;
	logic signed [DATA_BITS-1:0] pa;
	logic signed [DATA_BITS-1:0] pb;
	logic signed [DATA_BITS-1:0] best_nxt;
	logic signed [DATA_BITS-1:0] qmax;
	logic                        we;
	logic [NODE_BITS-1:0]        waddr;
	logic signed [DATA_BITS-1:0] wdata;
	logic [NODE_BITS-1:0]        raddr_a;
	logic [NODE_BITS-1:0]        raddr_b;

	assign left_ok  = (left_pos >= POS_MIN) && (left_pos <= POS_MAX);
	assign right_ok = (right_pos >= POS_MIN) && (right_pos <= POS_MAX);
	assign req_ok   = (req_type == REQ_WRITE) ? left_ok
	                : (left_ok && right_ok && (left_pos <= right_pos));
	assign leaf_wr  = cmd.load && req_ok && (req_type == REQ_WRITE);

	assign parent   = idx_q >> 1;
	assign wmax     = (cur_q > rd_a_q) ? cur_q : rd_a_q;
	assign pa       = fa_q ? rd_a_q : '0;
	assign pb       = fb_q ? rd_b_q : '0;
	assign best_nxt = (best_q > pair_q) ? best_q : pair_q;
	assign qmax     = best_nxt;

	assign sts.clr_last  = (clr_q == {NODE_BITS{1'b1}});
	assign sts.req_ok    = req_ok;
	assign sts.req_query = (req_type == REQ_QUERY);
	assign sts.wr_last   = (parent == NODE_BITS'(1));
	assign sts.q_more    = ((a_q ^ b_q ^ NODE_BITS'(1)) != '0);

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (leaf_wr) begin
			we    = 1'b1;
			waddr = {1'b1, left_pos};
			wdata = new_value;
		end else if (cmd.wr_upd) begin
			we    = 1'b1;
			waddr = parent;
			wdata = wmax;
		end
	end

	assign raddr_a = cmd.wr_read ? (idx_q ^ NODE_BITS'(1)) : (a_q ^ NODE_BITS'(1));
	assign raddr_b = b_q ^ NODE_BITS'(1);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + NODE_BITS'(1);
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q  <= {1'b1, left_pos};
			cur_q  <= new_value;
			a_q    <= {1'b1, left_pos - LEAF_BITS'(1)};
			b_q    <= {1'b1, right_pos + LEAF_BITS'(1)};
			best_q <= '0;
			pair_q <= '0;
		end
		if (cmd.wr_upd) begin
			cur_q <= wmax;
			idx_q <= parent;
		end
		if (cmd.q_read) begin
			fa_q   <= ~a_q[0];
			fb_q   <= b_q[0];
			a_q    <= a_q >> 1;
			b_q    <= b_q >> 1;
			best_q <= best_nxt;
		end
		if (cmd.q_pair) begin
			pair_q <= (pa > pb) ? pa : pb;
		end
		if (cmd.emit) begin
			max_q <= cmd.emit_query ? qmax[MAX_BITS-1:0] : '0;
			bad_q <= cmd.emit_bad;
		end
	end

	assign done        = done_q;
	assign max_value   = max_q;
	assign bad_request = bad_q;

endmodule
`default_nettype wire

// ===== verif/range_max_segment_tree_unit_tb.sv =====
`default_nettype none
module range_max_segment_tree_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmst_pkg::*;

	localparam int RANDOM_BEATS = 1030;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic                        kind;
		logic [LEAF_BITS-1:0]        lpos;
		logic [LEAF_BITS-1:0]        rpos;
		logic signed [DATA_BITS-1:0] val;
	} tree_req_t;

	typedef struct packed {
		logic [MAX_BITS-1:0] maxv;
		logic                bad;
	} tree_result_t;

	typedef struct packed {
		tree_req_t    req;
		logic         typed;
		tree_result_t res;
	} directed_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        req_type = REQ_WRITE;
	logic [LEAF_BITS-1:0]        left_pos = '0;
	logic [LEAF_BITS-1:0]        right_pos = '0;
	logic signed [DATA_BITS-1:0] new_value = '0;
	wire logic                   busy;
	wire logic                   done;
	wire logic [MAX_BITS-1:0]    max_value;
	wire logic                   bad_request;

	logic signed [DATA_BITS-1:0] node_max [NODE_COUNT];
	tree_result_t                pending_results[$];
	directed_row_t               directed_rows[$];
	tree_result_t                oldest;
	int                          mismatches = 0;
	int                          cycle_count = 0;

	range_max_segment_tree_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.left_pos    (left_pos),
		.right_pos   (right_pos),
		.new_value   (new_value),
		.done        (done),
		.max_value   (max_value),
		.bad_request (bad_request)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		mismatches++;
	endtask

	function automatic logic pos_valid(input logic [LEAF_BITS-1:0] p);
		return p >= POS_MIN && p <= POS_MAX;
	endfunction

	function automatic tree_result_t apply_request(input tree_req_t r);
		tree_result_t                res;
		int unsigned                 a;
		int unsigned                 b;
		logic signed [DATA_BITS-1:0] best;
		res = '0;
		best = '0;
		if (r.kind == REQ_WRITE) begin
			if (pos_valid(r.lpos)) begin
				a = LEAVES + r.lpos;
				node_max[a] = r.val;
				for (a = a >> 1; a != 0; a = a >> 1) begin
					if (node_max[2*a] > node_max[2*a+1])
						node_max[a] = node_max[2*a];
					else
						node_max[a] = node_max[2*a+1];
				end
			end else begin
				res.bad = 1'b1;
			end
		end else begin
			if (pos_valid(r.lpos) && pos_valid(r.rpos) && r.lpos <= r.rpos) begin
				a = r.lpos - 1 + LEAVES;
				b = r.rpos + 1 + LEAVES;
				while ((a ^ b ^ 1) != 0) begin
					if (a[0] == 1'b0 && node_max[(a ^ 1) % NODE_COUNT] > best)
						best = node_max[(a ^ 1) % NODE_COUNT];
					if (b[0] == 1'b1 && node_max[(b ^ 1) % NODE_COUNT] > best)
						best = node_max[(b ^ 1) % NODE_COUNT];
					a = a >> 1;
					b = b >> 1;
				end
				res.maxv = best[MAX_BITS-1:0];
			end else begin
				res.bad = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic logic signed [DATA_BITS-1:0] random_value();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(1000);
			2: return -$signed({1'b0, 31'($urandom_range(1000))});
			3: return 32'h7FFF_FFFF - $urandom_range(3);
			default: return 32'h8000_0000 + $urandom_range(3);
		endcase
	endfunction

	function automatic logic [LEAF_BITS-1:0] random_pos();
		case ($urandom_range(3))
			0: return LEAF_BITS'($urandom_range(8, POS_MIN));
			1: return LEAF_BITS'($urandom_range(POS_MAX, POS_MAX - 7));
			default: return LEAF_BITS'($urandom_range(POS_MAX, POS_MIN));
		endcase
	endfunction

	function automatic tree_req_t random_request();
		tree_req_t r;
		int        roll;
		int        top;
		roll = $urandom_range(99);
		r.val = random_value();
		r.rpos = LEAF_BITS'($urandom_range(1023));
		r.lpos = random_pos();
		if (roll < 45) begin
			r.kind = REQ_WRITE;
		end else if (roll < 90) begin
			r.kind = REQ_QUERY;
			if ($urandom_range(1)) begin
				top = r.lpos + $urandom_range(7);
				r.rpos = (top > POS_MAX) ? POS_MAX : top[LEAF_BITS-1:0];
			end else begin
				r.rpos = LEAF_BITS'($urandom_range(POS_MAX, r.lpos));
			end
		end else begin
			r.kind = 1'($urandom_range(1));
			r.lpos = LEAF_BITS'($urandom_range(1023));
			r.val = $urandom;
		end
		return r;
	endfunction

	task automatic send_beat(input tree_req_t r, input int idle_pct, input logic typed,
			input tree_result_t typed_res);
		tree_result_t predicted;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= r.kind;
		left_pos <= r.lpos;
		right_pos <= r.rpos;
		new_value <= r.val;
		do @(posedge clk); while (!(start && !busy));
		predicted = apply_request(r);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic add_row(input logic kind, input int lp, input int rp, input logic [31:0] v,
			input logic typed, input logic [MAX_BITS-1:0] mv, input logic bd);
		directed_row_t row;
		row.req = '{kind, lp[LEAF_BITS-1:0], rp[LEAF_BITS-1:0], v};
		row.typed = typed;
		row.res = '{mv, bd};
		directed_rows.push_back(row);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result max_value", -1, max_value);
			end else begin
				oldest = pending_results.pop_front();
				if (max_value !== oldest.maxv)
					report_mismatch("max_value", oldest.maxv, max_value);
				if (bad_request !== oldest.bad)
					report_mismatch("bad_request", oldest.bad, bad_request);
			end
		end
	end

	initial begin
		int idle_pct;
		foreach (node_max[i]) node_max[i] = '0;

		// kind, left, right, value, typed, max, bad
		add_row(REQ_QUERY, 1, 1022, 0, 1, 0, 0);
		add_row(REQ_QUERY, 0, 5, 0, 1, 0, 1);
		add_row(REQ_QUERY, 5, 1023, 0, 1, 0, 1);
		add_row(REQ_QUERY, 9, 8, 0, 1, 0, 1);
		add_row(REQ_WRITE, 0, 3, 32'd77, 1, 0, 1);
		add_row(REQ_WRITE, 1023, 1023, 32'h7FFF_FFFF, 1, 0, 1);
		add_row(REQ_WRITE, 1, 0, 32'h7FFF_FFFF, 1, 0, 0);
		add_row(REQ_WRITE, 1022, 1023, 32'h8000_0000, 1, 0, 0);
		add_row(REQ_WRITE, 512, 0, -32'sd5, 1, 0, 0);
		add_row(REQ_WRITE, 511, 1023, 32'd1000, 1, 0, 0);
		add_row(REQ_QUERY, 1, 1, 0, 1, 31'h7FFF_FFFF, 0);
		add_row(REQ_QUERY, 1022, 1022, 32'hFFFF_FFFF, 1, 0, 0);
		add_row(REQ_QUERY, 512, 512, 0, 1, 0, 0);
		add_row(REQ_QUERY, 2, 1022, 0, 0, 0, 0);
		add_row(REQ_QUERY, 511, 512, 0, 0, 0, 0);
		add_row(REQ_QUERY, 1, 1022, 0, 0, 0, 0);
		add_row(REQ_WRITE, 1, 0, 0, 1, 0, 0);
		add_row(REQ_QUERY, 1, 1022, 0, 0, 0, 0);
		add_row(REQ_QUERY, 1023, 1023, 0, 1, 0, 1);
		add_row(REQ_QUERY, 0, 0, 0, 1, 0, 1);
		add_row(REQ_WRITE, 300, 1023, 32'h5555_5555, 1, 0, 0);
		add_row(REQ_WRITE, 700, 1023, 32'hAAAA_AAAA, 1, 0, 0);
		add_row(REQ_QUERY, 300, 300, 0, 0, 0, 0);
		add_row(REQ_QUERY, 299, 701, 0, 0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_beat(directed_rows[i].req, 0, directed_rows[i].typed, directed_rows[i].res);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			case (i * 4 / RANDOM_BEATS)
				0: idle_pct = 0;
				1: idle_pct = 86;
				2: idle_pct = 35;
				default: idle_pct = ((i / 40) % 2) ? 86 : 0;
			endcase
			send_beat(random_request(), idle_pct, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
